### rtl/core/pll_divider_word_calc_unit_assert.svh
// ----------------------------------------------------------------------------
// PLL divider word calculator assertion macros
// Shared helpers for the concurrent checks of the divider word calculator.
// ----------------------------------------------------------------------------
`ifndef PLL_DIVIDER_WORD_CALC_UNIT_ASSERT_SVH
`define PLL_DIVIDER_WORD_CALC_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDW_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PDW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/pdw_pkg.sv
// ----------------------------------------------------------------------------
// PLL divider word calculator package
// Field widths, fixed register words and the word packing function.
// ----------------------------------------------------------------------------
`default_nettype none

package pdw_pkg;

   localparam int WORD_BITS = 24;
   localparam int R_BITS    = 14;
   localparam int N_BITS    = 13;
   localparam int VCO_BITS  = 16;

   localparam logic [VCO_BITS-1:0] VCO_RESET = 16'd56;

   localparam logic [WORD_BITS-1:0] FUNC_WORD_ALT = 24'h1F90C2;
   localparam logic [WORD_BITS-1:0] FUNC_WORD_STD = 24'h1F90A2;
   localparam logic [WORD_BITS-1:0] INIT_WORD_ALT = 24'h1F90C3;
   localparam logic [WORD_BITS-1:0] INIT_WORD_STD = 24'h1F90A3;
   localparam logic [WORD_BITS-1:0] DEF_REF_WORD   = 24'h010014;
   localparam logic [WORD_BITS-1:0] DEF_COUNT_WORD = 24'h201C01;
   localparam logic [WORD_BITS-1:0] DEF_FUNC_WORD  = 24'h1F90C6;
   localparam logic [WORD_BITS-1:0] DEF_INIT_WORD  = 24'h1F90C7;

   typedef struct packed {
      logic [WORD_BITS-1:0] ref_word;
      logic [WORD_BITS-1:0] count_word;
      logic [WORD_BITS-1:0] function_word;
      logic [WORD_BITS-1:0] init_word;
   } words_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic words_type pack_words(logic [R_BITS-1:0] r_val,
                                            logic [N_BITS-1:0] n_val,
                                            logic              var_sel,
                                            logic              zero_ref);
      words_type w;
      if (zero_ref) begin
         w.ref_word      = DEF_REF_WORD;
         w.count_word    = DEF_COUNT_WORD;
         w.function_word = DEF_FUNC_WORD;
         w.init_word     = DEF_INIT_WORD;
      end else begin
         w.ref_word      = {7'b0, 1'b1, r_val, 2'b00};
         w.count_word    = {2'b0, 1'b1, n_val, 6'b0, 2'b01};
         w.function_word = var_sel ? FUNC_WORD_ALT : FUNC_WORD_STD;
         w.init_word     = var_sel ? INIT_WORD_ALT : INIT_WORD_STD;
      end
      return w;
   endfunction

endpackage

`default_nettype wire

### rtl/core/pdw_channels.sv
// ----------------------------------------------------------------------------
// PLL divider word calculator channels
// Valid/ready interfaces for the request and response sides.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdw_req_if #(parameter int FREQ_BITS = 16) ();
   logic                 valid;
   logic                 ready;
   logic [FREQ_BITS-1:0] ref_freq;
   logic                 variant;

   modport source (output valid, output ref_freq, output variant, input ready);
   modport sink   (input valid, input ref_freq, input variant, output ready);
endinterface

interface pdw_rsp_if import pdw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] ref_word;
   logic [WORD_BITS-1:0] count_word;
   logic [WORD_BITS-1:0] function_word;
   logic [WORD_BITS-1:0] init_word;

   modport source (output valid, output ref_word, output count_word,
                   output function_word, output init_word, input ready);
   modport sink   (input valid, input ref_word, input count_word,
                   input function_word, input init_word, output ready);
endinterface

`default_nettype wire

### rtl/core/pdw_divider.sv
// ----------------------------------------------------------------------------
// PLL divider word calculator shared divider
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pll_divider_word_calc_unit_assert.svh"

module pdw_divider
   import pdw_pkg::*;
#(
   parameter int W = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire div_ctrl_type ctrl,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output div_stat_type      stat,
   output logic      [W-1:0] quotient,
   output logic      [W-1:0] remainder
);

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dsr_ff, dsr_in;

   logic [W:0]    shifted;
   logic [W+1:0]  diff;
   logic          fits;

   assign shifted = {rem_ff, quo_ff[W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dsr_ff};
   assign fits    = ~diff[W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (busy_ff) begin
         quo_in = {quo_ff[W-2:0], fits};
         rem_in = fits ? diff[W-1:0] : shifted[W-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   `PDW_ASSERT_NEXT(a_start_busy, clock, reset, ctrl.start && !busy_ff, busy_ff, "divider did not start")
   `PDW_ASSERT_SAME(a_done_idle, clock, reset, done_ff, !busy_ff, "done while still busy")
   `PDW_ASSERT_SAME(a_rem_below, clock, reset, done_ff, rem_ff < dsr_ff, "remainder not below divisor")

endmodule

`default_nettype wire

### rtl/core/pll_divider_word_calc_unit.sv
// ----------------------------------------------------------------------------
// PLL divider word calculator
// Finds R and N from the GCD of the reference and VCO frequencies and packs
// the four synthesizer register words.
// ----------------------------------------------------------------------------
// Usage:
// A request on req_chan carries ref_freq (MHz) and the variant flag; it is
// taken when valid and ready are both high. Ready is high only while the
// block is idle. One response per request appears on rsp_chan with the R,
// N, function and init words. The user must write the VCO frequency through
// csr_write_en / csr_write_data only while the block is idle; the block itself
// does not enforce this. Reset sets the VCO value to 56. A zero reference skips
// the arithmetic and the response passes through ST_DONE into the output
// register. Otherwise one shared restoring divider (one bit per cycle) runs the
// Euclid remainder steps and then R = ref/gcd and N = vco/gcd. There are up to
// about 23 Euclid remainder steps for 16-bit values. The next request can be
// taken in the cycle after the response is loaded. The result sits in an output
// register; a stalled receiver holds it, and the next request can be taken
// meanwhile but finishes only once the register has drained.
// Reset clears the sequencer and the response valid and reloads the VCO value.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pll_divider_word_calc_unit_assert.svh"

module pll_divider_word_calc_unit
   import pdw_pkg::*;
#(
   parameter int FREQ_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   pdw_req_if.sink                  req_chan,
   pdw_rsp_if.source                rsp_chan,
   input  wire logic                csr_write_en,
   input  wire logic [VCO_BITS-1:0] csr_write_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_TEST  = 3'd1;
   localparam logic [2:0] ST_WAIT  = 3'd2;
   localparam logic [2:0] ST_DIV_R = 3'd3;
   localparam logic [2:0] ST_DIV_N = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [FREQ_BITS-1:0] a_ff, a_in;
   logic [FREQ_BITS-1:0] b_ff, b_in;
   logic [FREQ_BITS-1:0] ref_ff, ref_in;
   logic                 var_ff, var_in;
   logic                 zero_ff, zero_in;
   logic [R_BITS-1:0]    r_ff, r_in;
   logic [N_BITS-1:0]    n_ff, n_in;
   words_type            out_ff, out_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VCO_BITS-1:0]  vco_ff;

   logic [31:0]          vco_wide;
   logic [FREQ_BITS-1:0] vco_val;
   logic [31:0]          quo_wide;

   div_ctrl_type         div_ctrl;
   div_stat_type         div_stat;
   logic [FREQ_BITS-1:0] div_dividend;
   logic [FREQ_BITS-1:0] div_divisor;
   logic [FREQ_BITS-1:0] div_quo;
   logic [FREQ_BITS-1:0] div_rem;

   pdw_divider #(.W(FREQ_BITS)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // The VCO setting is 16 bits; it is widened or cut to the frequency width.
   assign vco_wide = 32'(vco_ff);
   assign vco_val  = vco_wide[FREQ_BITS-1:0];
   assign quo_wide = 32'(div_quo);

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      ref_in         = ref_ff;
      var_in         = var_ff;
      zero_in        = zero_ff;
      r_in           = r_ff;
      n_in           = n_ff;
      out_in         = out_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      div_ctrl.start = 1'b0;
      div_dividend   = a_ff;
      div_divisor    = b_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               ref_in   = req_chan.ref_freq;
               var_in   = req_chan.variant;
               a_in     = req_chan.ref_freq;
               b_in     = vco_val;
               zero_in  = (req_chan.ref_freq == '0);
               state_in = (req_chan.ref_freq == '0) ? ST_DONE : ST_TEST;
            end
         end
         ST_TEST: begin
            div_ctrl.start = 1'b1;
            if (b_ff == '0) begin
               // The GCD is in a; divide the reference by it.
               div_dividend = ref_ff;
               div_divisor  = a_ff;
               state_in     = ST_DIV_R;
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (div_stat.done) begin
               a_in     = b_ff;
               b_in     = div_rem;
               state_in = ST_TEST;
            end
         end
         ST_DIV_R: begin
            if (div_stat.done) begin
               r_in           = quo_wide[R_BITS-1:0];
               div_ctrl.start = 1'b1;
               div_dividend   = vco_val;
               div_divisor    = a_ff;
               state_in       = ST_DIV_N;
            end
         end
         ST_DIV_N: begin
            if (div_stat.done) begin
               n_in     = quo_wide[N_BITS-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_in       = pack_words(r_ff, n_ff, var_ff, zero_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         vco_ff       <= VCO_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            vco_ff <= csr_write_data;
         end
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      ref_ff  <= ref_in;
      var_ff  <= var_in;
      zero_ff <= zero_in;
      r_ff    <= r_in;
      n_ff    <= n_in;
      out_ff  <= out_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.ref_word      = out_ff.ref_word;
   assign rsp_chan.count_word    = out_ff.count_word;
   assign rsp_chan.function_word = out_ff.function_word;
   assign rsp_chan.init_word     = out_ff.init_word;

   `PDW_ASSERT_SAME(a_wait_divisor, clock, reset, state_ff == ST_WAIT, b_ff != '0, "Euclid step with zero divisor")
   `PDW_ASSERT_SAME(a_start_free, clock, reset, div_ctrl.start, !div_stat.busy, "divider started while busy")
   `PDW_ASSERT_NEXT(a_accept_busy, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready, "ready right after a request")

endmodule

`default_nettype wire
